// ----- rtl/core/qte_pkg.sv -----
package qte_pkg;

  // Field and datapath widths.
  localparam int QW         = 16;  // quaternion component, Q1.14
  localparam int PW         = 32;  // exact product of two components
  localparam int OPW        = 35;  // atan2 operands in Q2.28, factor of two included
  localparam int SW         = 30;  // saturated sine argument, Q2.28
  localparam int CW         = 58;  // CORDIC x and y after the 2^20 scale
  localparam int ZW         = 24;  // CORDIC angle, 2^-20 rad
  localparam int ROOT_W     = 29;  // floor square root of a value up to 2^56
  localparam int RW         = 58;  // square root remainder and partial root
  localparam int ITERS      = 20;  // CORDIC micro-rotations
  localparam int SCALE_SH   = 20;  // operand scale before the rotations
  localparam int FIFO_DEPTH = 4;

  localparam int OUT_RW  = 16;
  localparam int OUT_PW  = 16;
  localparam int OUT_YW  = 15;
  localparam int LIM_W   = 17;

  localparam logic signed [ZW-1:0]    ANG_PI   = ZW'(3294199);
  localparam logic signed [SW-1:0]    ONE_Q28  = SW'(268435456);
  localparam logic signed [LIM_W-1:0] LIM_FULL = LIM_W'(25736);
  localparam logic signed [LIM_W-1:0] LIM_HALF = LIM_W'(12868);

  typedef struct packed {
    logic signed [OPW-1:0] roll_y;
    logic signed [OPW-1:0] roll_x;
    logic signed [OPW-1:0] pitch_y;
    logic signed [OPW-1:0] pitch_x;
    logic signed [SW-1:0]  sin_arg;
  } oper_t;

  // round(atan(2^-i) * 2^20)
  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = ZW'(823550);
      5'd1:    v = ZW'(486170);
      5'd2:    v = ZW'(256879);
      5'd3:    v = ZW'(130396);
      5'd4:    v = ZW'(65451);
      5'd5:    v = ZW'(32757);
      5'd6:    v = ZW'(16383);
      5'd7:    v = ZW'(8192);
      5'd8:    v = ZW'(4096);
      5'd9:    v = ZW'(2048);
      5'd10:   v = ZW'(1024);
      5'd11:   v = ZW'(512);
      5'd12:   v = ZW'(256);
      5'd13:   v = ZW'(128);
      5'd14:   v = ZW'(64);
      5'd15:   v = ZW'(32);
      5'd16:   v = ZW'(16);
      5'd17:   v = ZW'(8);
      5'd18:   v = ZW'(4);
      5'd19:   v = ZW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half up from 2^-20 to 2^-13 rad, then clamp to +-lim.
  function automatic logic signed [LIM_W-1:0] round_clamp(input logic signed [ZW-1:0] z,
                                                          input logic signed [LIM_W-1:0] lim);
    logic signed [ZW:0]   t;
    logic signed [ZW-7:0] r;
    logic signed [ZW-7:0] hi;
    logic signed [LIM_W-1:0] res;
    t  = {z[ZW-1], z} + (ZW+1)'(64);
    r  = t[ZW:7];
    hi = (ZW-6)'(lim);
    if (r > hi) begin
      res = lim;
    end else if (r < -hi) begin
      res = -lim;
    end else begin
      res = LIM_W'(r);
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/qte_front.sv -----
module qte_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   quat_a,
  input  logic signed [15:0]   quat_b,
  input  logic signed [15:0]   quat_c,
  input  logic signed [15:0]   quat_d,
  output logic                 push,
  output qte_pkg::oper_t       oper,
  input  logic                 full
);

  localparam int OPW = qte_pkg::OPW;
  localparam int SW  = qte_pkg::SW;

  logic                         q_vld;
  logic signed [qte_pkg::QW-1:0] qa, qb, qc, qd;
  logic                         p_vld;
  logic signed [qte_pkg::PW-1:0] aa, ab, ac, ad, bb, bc, bd, cc, cd, dd;
  logic                         fe;
  logic signed [OPW-1:0]        s_wide;

  assign fe       = !p_vld || !full;
  assign in_ready = fe;
  assign push     = p_vld && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
      p_vld <= 1'b0;
    end else if (fe) begin
      q_vld <= in_valid;
      p_vld <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      if (in_valid) begin
        qa <= quat_a;
        qb <= quat_b;
        qc <= quat_c;
        qd <= quat_d;
      end
      aa <= qa * qa;
      ab <= qa * qb;
      ac <= qa * qc;
      ad <= qa * qd;
      bb <= qb * qb;
      bc <= qb * qc;
      bd <= qb * qd;
      cc <= qc * qc;
      cd <= qc * qd;
      dd <= qd * qd;
    end
  end

  // Operand sums; the sine argument is saturated to plus or minus one.
  always_comb begin
    oper.roll_y  = (OPW'(cd) + OPW'(ab)) <<< 1;
    oper.roll_x  = OPW'(aa) - OPW'(bb) - OPW'(cc) + OPW'(dd);
    oper.pitch_y = (OPW'(bc) + OPW'(ad)) <<< 1;
    oper.pitch_x = OPW'(cc) + OPW'(dd) - OPW'(aa) - OPW'(bb);
    s_wide       = (OPW'(ac) - OPW'(bd)) <<< 1;
    if (s_wide > OPW'(qte_pkg::ONE_Q28)) begin
      oper.sin_arg = qte_pkg::ONE_Q28;
    end else if (s_wide < -OPW'(qte_pkg::ONE_Q28)) begin
      oper.sin_arg = -qte_pkg::ONE_Q28;
    end else begin
      oper.sin_arg = SW'(s_wide);
    end
  end

endmodule

// ----- rtl/core/qte_fifo.sv -----
module qte_fifo #(
  parameter int DEPTH = qte_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qte_pkg::oper_t wdata,
  output logic           full,
  input  logic           pop,
  output qte_pkg::oper_t rdata,
  output logic           empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  qte_pkg::oper_t  mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- rtl/core/qte_cos.sv -----
module qte_cos (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [qte_pkg::SW-1:0]       sin_in,
  output logic signed [qte_pkg::SW-1:0]       sin_out,
  output logic        [qte_pkg::ROOT_W-1:0]   cos_out
);

  localparam int SW     = qte_pkg::SW;
  localparam int ROOT_W = qte_pkg::ROOT_W;
  localparam int RW     = qte_pkg::RW;

  logic [RW-1:0]          v_st   [ROOT_W+1];
  logic [RW-1:0]          r_st   [ROOT_W+1];
  logic signed [SW-1:0]   sin_st [ROOT_W+1];
  logic [ROOT_W-1:0]      mag;
  logic [2*ROOT_W-1:0]    mag_sq;

  assign mag    = sin_in[SW-1] ? ROOT_W'(-sin_in) : ROOT_W'(sin_in);
  assign mag_sq = mag * mag;

  // First stage: radicand 2^56 - s^2.
  always_ff @(posedge clk) begin
    if (en) begin
      v_st[0]   <= (RW'(1) << (2 * (ROOT_W - 1))) - RW'(mag_sq);
      r_st[0]   <= '0;
      sin_st[0] <= sin_in;
    end
  end

  // One root bit per stage, restoring recurrence.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam logic [RW-1:0] B = RW'(1) << (2 * (ROOT_W - 1 - k));
    logic [RW-1:0] trial;
    assign trial = r_st[k] + B;
    always_ff @(posedge clk) begin
      if (en) begin
        sin_st[k+1] <= sin_st[k];
        if (v_st[k] >= trial) begin
          v_st[k+1] <= v_st[k] - trial;
          r_st[k+1] <= (r_st[k] >> 1) + B;
        end else begin
          v_st[k+1] <= v_st[k];
          r_st[k+1] <= r_st[k] >> 1;
        end
      end
    end
  end

  assign cos_out = r_st[ROOT_W][ROOT_W-1:0];
  assign sin_out = sin_st[ROOT_W];

endmodule

// ----- rtl/core/qte_cordic.sv -----
module qte_cordic (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [qte_pkg::OPW-1:0]  y_in,
  input  logic signed [qte_pkg::OPW-1:0]  x_in,
  output logic signed [qte_pkg::ZW-1:0]   z_out
);

  localparam int CW    = qte_pkg::CW;
  localparam int ZW    = qte_pkg::ZW;
  localparam int ITERS = qte_pkg::ITERS;

  logic signed [CW-1:0] x_st [ITERS+1];
  logic signed [CW-1:0] y_st [ITERS+1];
  logic signed [ZW-1:0] z_st [ITERS+1];
  logic                 zero_st [ITERS+1];
  logic signed [CW-1:0] xe, ye;

  assign xe = CW'(x_in);
  assign ye = CW'(y_in);

  // Left half plane: flip the vector and start from plus or minus pi.
  always_ff @(posedge clk) begin
    if (en) begin
      zero_st[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[qte_pkg::OPW-1]) begin
        x_st[0] <= (-xe) <<< qte_pkg::SCALE_SH;
        y_st[0] <= (-ye) <<< qte_pkg::SCALE_SH;
        z_st[0] <= y_in[qte_pkg::OPW-1] ? -qte_pkg::ANG_PI : qte_pkg::ANG_PI;
      end else begin
        x_st[0] <= xe <<< qte_pkg::SCALE_SH;
        y_st[0] <= ye <<< qte_pkg::SCALE_SH;
        z_st[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_rot
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] ang;
    assign dx  = y_st[i] >>> i;
    assign dy  = x_st[i] >>> i;
    assign ang = qte_pkg::atan_entry(5'(i));
    always_ff @(posedge clk) begin
      if (en) begin
        zero_st[i+1] <= zero_st[i];
        if (!y_st[i][CW-1]) begin
          x_st[i+1] <= x_st[i] + dx;
          y_st[i+1] <= y_st[i] - dy;
          z_st[i+1] <= z_st[i] + ang;
        end else begin
          x_st[i+1] <= x_st[i] - dx;
          y_st[i+1] <= y_st[i] + dy;
          z_st[i+1] <= z_st[i] - ang;
        end
      end
    end
  end

  assign z_out = zero_st[ITERS] ? '0 : z_st[ITERS];

endmodule

// ----- rtl/core/quaternion_to_euler_angles.sv -----
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  s_tdata[63:0]: quat_a, quat_b, quat_c, quat_d
// m_*      out        m_tvalid/m_tready  m_tdata[47:0]: roll_angle, pitch_angle, yaw_angle
//
// One quaternion word is accepted per cycle unless a full queue holds the front, and one
// angle word leaves per cycle while m_tready is high. With the output side ready, the angle
// word is valid once its quaternion word has passed the input register at the accepting
// edge, then the product stage, the queue write, the pop register, the square root
// (30 stages), the yaw CORDIC (21 stages) and the output register. Square root sets depth.
// Reset (rst, synchronous) empties the front stages, the queue and the back pipeline.
// A stalled output freezes the back pipeline; the queue keeps the front accepting until full.
module quaternion_to_euler_angles #(
  parameter int FIFO_DEPTH = qte_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // quat_a [15:0], quat_b [31:16], quat_c [47:32], quat_d [63:48]
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // roll_angle [15:0], pitch_angle [31:16], yaw_angle [46:32], zero [47]
  output logic [47:0] m_tdata
);

  localparam int ZW    = qte_pkg::ZW;
  localparam int OPW   = qte_pkg::OPW;
  // Back pipeline from the pop register to the last CORDIC stage.
  localparam int LAT   = 1 + (qte_pkg::ROOT_W + 1) + (qte_pkg::ITERS + 1);
  // Roll and pitch finish early and wait for yaw.
  localparam int DLY   = qte_pkg::ROOT_W + 1;

  logic           push, full, empty, pop, adv;
  qte_pkg::oper_t fr_oper, q_oper, b0;
  logic           vld [LAT];

  logic signed [qte_pkg::SW-1:0]     sin_d;
  logic        [qte_pkg::ROOT_W-1:0] cos_d;
  logic signed [ZW-1:0]              roll_z, pitch_z, yaw_z;
  logic signed [ZW-1:0]              roll_dl  [DLY];
  logic signed [ZW-1:0]              pitch_dl [DLY];
  logic signed [qte_pkg::LIM_W-1:0]  roll_r, pitch_r, yaw_r;

  qte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .quat_a   (s_tdata[15:0]),
    .quat_b   (s_tdata[31:16]),
    .quat_c   (s_tdata[47:32]),
    .quat_d   (s_tdata[63:48]),
    .push     (push),
    .oper     (fr_oper),
    .full     (full)
  );

  qte_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (fr_oper),
    .full  (full),
    .pop   (pop),
    .rdata (q_oper),
    .empty (empty)
  );

  // The whole back end moves together whenever the output register can take a word.
  assign adv = !m_tvalid || m_tready;
  assign pop = adv && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        vld[k] <= 1'b0;
      end
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld[0] <= pop;
      for (int k = 1; k < LAT; k++) begin
        vld[k] <= vld[k-1];
      end
      m_tvalid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0 <= q_oper;
    end
  end

  qte_cordic u_roll (
    .clk   (clk),
    .en    (adv),
    .y_in  (b0.roll_y),
    .x_in  (b0.roll_x),
    .z_out (roll_z)
  );

  qte_cordic u_pitch (
    .clk   (clk),
    .en    (adv),
    .y_in  (b0.pitch_y),
    .x_in  (b0.pitch_x),
    .z_out (pitch_z)
  );

  // Yaw is asin(s), computed as atan2(s, sqrt(1 - s^2)).
  qte_cos u_cos (
    .clk     (clk),
    .en      (adv),
    .sin_in  (b0.sin_arg),
    .sin_out (sin_d),
    .cos_out (cos_d)
  );

  qte_cordic u_yaw (
    .clk   (clk),
    .en    (adv),
    .y_in  (OPW'(sin_d)),
    .x_in  (signed'(OPW'(cos_d))),
    .z_out (yaw_z)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_dl[0]  <= roll_z;
      pitch_dl[0] <= pitch_z;
      for (int k = 1; k < DLY; k++) begin
        roll_dl[k]  <= roll_dl[k-1];
        pitch_dl[k] <= pitch_dl[k-1];
      end
    end
  end

  assign roll_r  = qte_pkg::round_clamp(roll_dl[DLY-1], qte_pkg::LIM_FULL);
  assign pitch_r = qte_pkg::round_clamp(pitch_dl[DLY-1], qte_pkg::LIM_FULL);
  assign yaw_r   = qte_pkg::round_clamp(yaw_z, qte_pkg::LIM_HALF);

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {1'b0, yaw_r[qte_pkg::OUT_YW-1:0], pitch_r[qte_pkg::OUT_PW-1:0],
                  roll_r[qte_pkg::OUT_RW-1:0]};
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

  // Expected angles for one quaternion word.
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [14:0] yaw;
  } angles_t;

  // Vectoring CORDIC atan2, result in 2^-20 rad.
  function automatic longint cordic_atan2(input longint y_in, input longint x_in);
    longint x, y, z, dx, dy;
    longint base;
    longint step [20];
    step = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
             4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    x = x_in;
    y = y_in;
    z = 0;
    base = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? 64'sd3294199 : -64'sd3294199;
      x = -x;
      y = -y;
    end
    x = x * 1048576;
    y = y * 1048576;
    for (int i = 0; i < 20; i++) begin
      // >>> on a signed longint is a floor shift.
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += step[i];
      end else begin
        x -= dx;
        y += dy;
        z -= step[i];
      end
    end
    return base + z;
  endfunction

  function automatic longint round_to_out(input longint z, input longint lim);
    longint r;
    r = (z + 64) >>> 7;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint floor_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic angles_t quat_to_angles(input logic [63:0] word);
    longint a, b, c, d, s, mag;
    longint aa, ab, ac, ad, bb, bc, bd, cc, cd, dd;
    angles_t res;
    a = longint'($signed(word[15:0]));
    b = longint'($signed(word[31:16]));
    c = longint'($signed(word[47:32]));
    d = longint'($signed(word[63:48]));
    aa = a * a; ab = a * b; ac = a * c; ad = a * d;
    bb = b * b; bc = b * c; bd = b * d;
    cc = c * c; cd = c * d; dd = d * d;
    res.roll = 16'(round_to_out(cordic_atan2(2 * (cd + ab), aa - bb - cc + dd), 25736));
    res.pitch = 16'(round_to_out(cordic_atan2(2 * (bc + ad), -(aa + bb - cc - dd)), 25736));
    // The sine argument saturates to +-1 in Q2.28 before the cosine is formed.
    s = 2 * (ac - bd);
    if (s > 268435456) s = 268435456;
    if (s < -268435456) s = -268435456;
    mag = (s < 0) ? -s : s;
    res.yaw = 15'(round_to_out(cordic_atan2(s, floor_root((64'd1 << 56) - mag * mag)),
                               12868));
    return res;
  endfunction

  class angle_scoreboard;
    angles_t pending[$];
    int errors = 0;

    function void note_quat(logic [63:0] word);
      pending.push_back(quat_to_angles(word));
    endfunction

    function void check_angles(logic [47:0] word);
      angles_t exp_a;
      if (pending.size() == 0) begin
        $display("%0t: unexpected angle word %h", $time, word);
        errors++;
        return;
      end
      exp_a = pending.pop_front();
      if (word[15:0] !== exp_a.roll) begin
        $display("%0t: roll expected %0d actual %0d", $time, exp_a.roll,
                 $signed(word[15:0]));
        errors++;
      end
      if (word[31:16] !== exp_a.pitch) begin
        $display("%0t: pitch expected %0d actual %0d", $time, exp_a.pitch,
                 $signed(word[31:16]));
        errors++;
      end
      if (word[46:32] !== exp_a.yaw) begin
        $display("%0t: yaw expected %0d actual %0d", $time, exp_a.yaw,
                 $signed(word[46:32]));
        errors++;
      end
      if (word[47] !== 1'b0) begin
        $display("%0t: pad bit expected 0 actual %b", $time, word[47]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;

  angle_scoreboard sb = new();
  // Idling is switched off over a stretch of the random part.
  bit steady = 1'b0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  quaternion_to_euler_angles dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Receiver: stalls about 7 percent of the time unless steady; checks accepted words.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_angles(m_tdata);
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 7);
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > 2000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sends one quaternion word, with a random gap ahead of it, and holds it until taken.
  task automatic send_quat(input logic signed [15:0] qa, qb, qc, qd);
    while (!steady && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {qd, qc, qb, qa};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_quat({qd, qc, qb, qa});
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(9))
      0: return 16'($urandom());
      1: return 16'(16384);
      2: return -16'sd16384;
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  // Unit-norm quaternion with small random error, so the angles cover their ranges.
  task automatic send_unit_quat();
    real qa, qb, qc, qd, n;
    qa = $urandom_range(20000) - 10000.0;
    qb = $urandom_range(20000) - 10000.0;
    qc = $urandom_range(20000) - 10000.0;
    qd = $urandom_range(20000) - 10000.0;
    n = $sqrt(qa * qa + qb * qb + qc * qc + qd * qd);
    if (n < 1.0) n = 1.0;
    send_quat(16'($rtoi(qa / n * 16384.0) + $urandom_range(4) - 2),
              16'($rtoi(qb / n * 16384.0) + $urandom_range(4) - 2),
              16'($rtoi(qc / n * 16384.0) + $urandom_range(4) - 2),
              16'($rtoi(qd / n * 16384.0) + $urandom_range(4) - 2));
  endtask

  initial begin
    int drain;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity, zero, the half-turn axes, asin saturation, extreme codes.
    send_quat(16384, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(-16384, 0, 0, 0);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(16384, 0, 16384, 0);
    send_quat(16384, -16384, 16384, 16384);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(0, 0, -16384, 1);
    send_quat(-1, 0, 0, 0);
    send_quat(0, -1, 0, -1);
    send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);

    // Hold off until every expected word has come back.
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);

    for (int n = 0; n < 750; n++) begin
      steady = (n >= 300 && n < 450);
      if ($urandom_range(99) < 70) begin
        send_unit_quat();
      end else begin
        send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    drain = 0;
    while (sb.pending.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/qte_pkg.sv
rtl/core/qte_front.sv
rtl/core/qte_fifo.sv
rtl/core/qte_cos.sv
rtl/core/qte_cordic.sv
rtl/core/quaternion_to_euler_angles.sv
dv/tb.sv
